// ===== hdl/lhtbl_pkg.sv =====
// ----------------------------------------------------------------------------
// lhtbl_pkg
// Shared types, codes and defaults for the linear probing hash table.
// ----------------------------------------------------------------------------
package lhtbl_pkg;

    localparam int TABLE_SIZE_DEF = 16;
    localparam int KEY_BYTES_DEF  = 8;

    localparam int KEY_W    = 64;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;
    localparam int FUNC_W   = 2;

    typedef logic [FUNC_W-1:0] t_func;
    localparam t_func FUNC_INSERT = 2'd0;
    localparam t_func FUNC_SEARCH = 2'd1;
    localparam t_func FUNC_DELETE = 2'd2;

    typedef logic [1:0] t_mark;
    localparam t_mark MARK_EMPTY   = 2'd0;
    localparam t_mark MARK_USED    = 2'd1;
    localparam t_mark MARK_DELETED = 2'd2;

    typedef logic [STATUS_W-1:0] t_status;
    localparam t_status ST_INSERTED  = 3'd0;
    localparam t_status ST_UPDATED   = 3'd1;
    localparam t_status ST_FOUND     = 3'd2;
    localparam t_status ST_NOT_FOUND = 3'd3;
    localparam t_status ST_FULL      = 3'd4;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_READ,
        S_CHECK
    } t_state;

    typedef struct packed {
        logic    clear_step;
        logic    load;
        logic    mod_step;
        logic    rd;
        logic    advance;
        logic    wr_mark;
        t_mark   mark_val;
        logic    wr_kv;
        logic    set_result;
        t_status res_status;
        logic    res_use_value;
    } t_ctrl_cmd;

    typedef struct packed {
        logic  clear_last;
        logic  mod_last;
        t_func func;
        t_mark mark;
        logic  key_match;
        logic  probe_last;
    } t_dp_status;

endpackage

// ===== hdl/linear_probe_hash_table.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressed key/value table with linear probing and tombstones.
// ----------------------------------------------------------------------------
// After reset the block sweeps the slot marks, one slot a cycle, and holds busy
// high until the sweep is done. A request is taken when start is high and busy
// low. The home slot is found by a reciprocal multiply split into a quotient
// step and a remainder step, and each probed slot then takes a registered RAM
// read followed by a compare and write back. The result is registered and
// strobed on o_done once the last probed slot is checked, or after the remainder
// step for the unused function code; busy is low again in the strobe cycle.
// The result is valid only in the o_done cycle.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
    parameter int TABLE_SIZE = lhtbl_pkg::TABLE_SIZE_DEF,
    parameter int KEY_BYTES  = lhtbl_pkg::KEY_BYTES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [lhtbl_pkg::FUNC_W-1:0]         i_func,
    input  logic [lhtbl_pkg::KEY_W-1:0]          i_key,
    input  logic signed [lhtbl_pkg::VALUE_W-1:0] i_value,
    output logic                                 o_done,
    output logic [lhtbl_pkg::STATUS_W-1:0]       o_status,
    output logic signed [lhtbl_pkg::VALUE_W-1:0] o_found_value,
    output logic [lhtbl_pkg::SLOT_W-1:0]         o_slot
);
    import lhtbl_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status stat;

    lhtbl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    lhtbl_dp #(
        .TABLE_SIZE (TABLE_SIZE),
        .KEY_BYTES  (KEY_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_func        (i_func),
        .i_key         (i_key),
        .i_value       (i_value),
        .o_stat        (stat),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_found_value (o_found_value),
        .o_slot        (o_slot)
    );

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_NOT_FOUND || o_status == ST_FULL)) |-> (o_slot == '0))
        else $error("slot not zero on miss or full");

    a_value_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_found_value != '0) |-> (o_status == ST_FOUND))
        else $error("value returned without a hit");

endmodule

// ===== hdl/lhtbl_ram.sv =====
// ----------------------------------------------------------------------------
// lhtbl_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lhtbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/lhtbl_ctrl.sv =====
// ----------------------------------------------------------------------------
// lhtbl_ctrl
// Sequencer for clearing, hashing, probing and result issue.
// ----------------------------------------------------------------------------
module lhtbl_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  lhtbl_pkg::t_dp_status i_stat,
    output lhtbl_pkg::t_ctrl_cmd  o_cmd,
    output logic                  busy
);
    import lhtbl_pkg::*;

    t_state  r_state;
    t_state  n_state;

    logic    fin;
    t_status fin_status;
    logic    fin_use_value;
    logic    fin_wr_mark;
    t_mark   fin_mark_val;
    logic    fin_wr_kv;
    logic    func_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign func_ok = (i_stat.func == FUNC_INSERT) || (i_stat.func == FUNC_SEARCH)
                  || (i_stat.func == FUNC_DELETE);

    always_comb begin
        fin           = 1'b0;
        fin_status    = ST_NOT_FOUND;
        fin_use_value = 1'b0;
        fin_wr_mark   = 1'b0;
        fin_mark_val  = MARK_USED;
        fin_wr_kv     = 1'b0;
        if (i_stat.func == FUNC_INSERT) begin
            if (i_stat.mark != MARK_USED) begin
                fin         = 1'b1;
                fin_status  = ST_INSERTED;
                fin_wr_mark = 1'b1;
                fin_wr_kv   = 1'b1;
            end else if (i_stat.key_match) begin
                fin        = 1'b1;
                fin_status = ST_UPDATED;
                fin_wr_kv  = 1'b1;
            end else if (i_stat.probe_last) begin
                fin        = 1'b1;
                fin_status = ST_FULL;
            end
        end else begin
            if (i_stat.mark == MARK_EMPTY) begin
                fin = 1'b1;
            end else if (i_stat.mark == MARK_USED && i_stat.key_match) begin
                fin        = 1'b1;
                fin_status = ST_FOUND;
                if (i_stat.func == FUNC_DELETE) begin
                    fin_wr_mark  = 1'b1;
                    fin_mark_val = MARK_DELETED;
                end else begin
                    fin_use_value = 1'b1;
                end
            end else if (i_stat.probe_last) begin
                fin = 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) n_state = S_MOD;
            end
            S_MOD: begin
                if (i_stat.mod_last) n_state = func_ok ? S_READ : S_IDLE;
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = fin ? S_IDLE : S_READ;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.mark_val   = MARK_USED;
        o_cmd.res_status = ST_NOT_FOUND;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
            end
            S_IDLE: begin
                o_cmd.load = start;
            end
            S_MOD: begin
                o_cmd.mod_step   = 1'b1;
                o_cmd.set_result = i_stat.mod_last && !func_ok;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
            end
            S_CHECK: begin
                o_cmd.advance       = !fin;
                o_cmd.wr_mark       = fin_wr_mark;
                o_cmd.mark_val      = fin_mark_val;
                o_cmd.wr_kv         = fin_wr_kv;
                o_cmd.set_result    = fin;
                o_cmd.res_status    = fin_status;
                o_cmd.res_use_value = fin_use_value;
            end
            default: begin
                o_cmd.res_status = ST_NOT_FOUND;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

// ===== hdl/lhtbl_dp.sv =====
// ----------------------------------------------------------------------------
// lhtbl_dp
// Key cleanup, byte-sum hash, modulo reduction, slot storage and results.
// ----------------------------------------------------------------------------
module lhtbl_dp #(
    parameter int TABLE_SIZE = 16,
    parameter int KEY_BYTES  = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  lhtbl_pkg::t_ctrl_cmd                 i_cmd,
    input  logic [lhtbl_pkg::FUNC_W-1:0]         i_func,
    input  logic [lhtbl_pkg::KEY_W-1:0]          i_key,
    input  logic signed [lhtbl_pkg::VALUE_W-1:0] i_value,
    output lhtbl_pkg::t_dp_status                o_stat,
    output logic                                 o_done,
    output logic [lhtbl_pkg::STATUS_W-1:0]       o_status,
    output logic signed [lhtbl_pkg::VALUE_W-1:0] o_found_value,
    output logic [lhtbl_pkg::SLOT_W-1:0]         o_slot
);
    import lhtbl_pkg::*;

    localparam int IDX_W     = $clog2(TABLE_SIZE);
    localparam int SUM_MAX   = KEY_BYTES * 255;
    localparam int SUM_W     = $clog2(SUM_MAX + 1);
    localparam int RECIP_SH  = SUM_W + IDX_W;
    localparam int RECIP_M   = ((1 << RECIP_SH) + TABLE_SIZE - 1) / TABLE_SIZE;
    localparam int MOD_N     = 2;
    localparam int MS_W      = $clog2(MOD_N + 1);

    t_func              r_func;
    logic [KEY_W-1:0]   r_key;
    logic [VALUE_W-1:0] r_value;
    logic [SUM_W-1:0]   r_sum;
    logic [SUM_W-1:0]   r_quot;
    logic [MS_W-1:0]    r_mstep;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   r_cnt;
    logic [IDX_W-1:0]   r_clr;
    logic               r_done;
    t_status            r_status;
    logic [VALUE_W-1:0] r_fval;
    logic [SLOT_W-1:0]  r_slot;

    logic [KEY_W-1:0]   ckey;
    logic [SUM_W-1:0]   csum;
    logic               alive;
    logic [7:0]         kbyte;
    logic [31:0]        sum_ext;
    logic [31:0]        quot;
    logic [31:0]        n_red;
    logic [31:0]        idx_ext;
    logic [IDX_W-1:0]   n_idx_inc;

    logic               mark_we;
    logic [IDX_W-1:0]   mark_waddr;
    t_mark              mark_wdata;
    t_mark              mark_rd;
    logic [KEY_W-1:0]   key_rd;
    logic [VALUE_W-1:0] value_rd;

    always_comb begin
        ckey  = '0;
        csum  = '0;
        alive = 1'b1;
        kbyte = '0;
        for (int i = 0; i < 8; i++) begin
            kbyte = i_key[8*i +: 8];
            if (i < KEY_BYTES && alive && kbyte != 8'd0) begin
                ckey[8*i +: 8] = kbyte;
                csum           = csum + SUM_W'(kbyte);
            end else begin
                alive = 1'b0;
            end
        end
    end

    // quotient by reciprocal multiply, remainder from the registered quotient in the next step
    assign sum_ext   = 32'(r_sum);
    assign quot      = (sum_ext * 32'(RECIP_M)) >> RECIP_SH;
    assign n_red     = sum_ext - (32'(r_quot) * 32'(TABLE_SIZE));
    assign n_idx_inc = (r_idx == IDX_W'(TABLE_SIZE - 1)) ? '0 : r_idx + 1'b1;
    assign idx_ext   = 32'(r_idx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_key   <= ckey;
            r_value <= i_value;
            r_sum   <= csum;
            r_mstep <= MS_W'(MOD_N - 1);
        end
        if (i_cmd.mod_step) begin
            r_quot  <= quot[SUM_W-1:0];
            r_mstep <= r_mstep - 1'b1;
            r_idx   <= n_red[IDX_W-1:0];
            r_cnt   <= '0;
        end
        if (i_cmd.advance) begin
            r_idx <= n_idx_inc;
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.set_result) begin
            r_status <= i_cmd.res_status;
            r_fval   <= i_cmd.res_use_value ? value_rd : '0;
            case (i_cmd.res_status) inside
                ST_INSERTED, ST_UPDATED, ST_FOUND: r_slot <= idx_ext[SLOT_W-1:0];
                default:                           r_slot <= '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.set_result;
            if (i_cmd.clear_step) begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    assign mark_we    = i_cmd.clear_step || i_cmd.wr_mark;
    assign mark_waddr = i_cmd.clear_step ? r_clr : r_idx;
    assign mark_wdata = i_cmd.clear_step ? MARK_EMPTY : i_cmd.mark_val;

    lhtbl_ram #(.WIDTH(2), .DEPTH(TABLE_SIZE)) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (mark_we),
        .i_waddr (mark_waddr),
        .i_wdata (mark_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (r_idx),
        .o_rdata (mark_rd)
    );

    lhtbl_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_SIZE)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_kv),
        .i_waddr (r_idx),
        .i_wdata (r_key),
        .i_re    (i_cmd.rd),
        .i_raddr (r_idx),
        .o_rdata (key_rd)
    );

    lhtbl_ram #(.WIDTH(VALUE_W), .DEPTH(TABLE_SIZE)) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_kv),
        .i_waddr (r_idx),
        .i_wdata (r_value),
        .i_re    (i_cmd.rd),
        .i_raddr (r_idx),
        .o_rdata (value_rd)
    );

    assign o_stat.clear_last = (r_clr == IDX_W'(TABLE_SIZE - 1));
    assign o_stat.mod_last   = (r_mstep == '0);
    assign o_stat.func       = r_func;
    assign o_stat.mark       = mark_rd;
    assign o_stat.key_match  = (key_rd == r_key);
    assign o_stat.probe_last = (r_cnt == IDX_W'(TABLE_SIZE - 1));

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_found_value = r_fval;
    assign o_slot        = r_slot;

endmodule

// ===== bench/linear_probe_hash_table_test.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table_test
// Self-checking bench for the linear probing hash table. A short table of
// directed requests covers the empty table, the all-zero and all-ones keys,
// keys with bytes past the terminating zero, tombstone skipping and claiming,
// and the unused function code. Random rounds follow that alternate between
// filling, churning and reading a small pool of colliding keys, so that full
// tables and long probe chains occur. Each result is compared with the typed
// reply of its directed row, else with a behavioral copy of the slot store.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lhtbl_pkg::*;

    localparam int    N_SLOTS        = TABLE_SIZE_DEF;
    localparam t_func FUNC_UNUSED    = 2'd3;
    localparam int    WATCHDOG_LIMIT = 1000;
    localparam int    DRAIN_CYCLES   = 60;
    localparam int    RANDOM_WORDS   = 2000;
    localparam int    CALM_WORDS     = 300;
    localparam int    ROUND_WORDS    = 100;
    localparam int    POOL_SIZE      = 24;
    localparam int    N_DIRECTED     = 22;

    typedef struct packed {
        t_status                   status;
        logic signed [VALUE_W-1:0] fval;
        logic [SLOT_W-1:0]         slot;
    } t_reply;

    typedef struct packed {
        t_func                     func;
        logic [KEY_W-1:0]          key;
        logic signed [VALUE_W-1:0] value;
        bit                        typed;
        t_reply                    reply;
    } t_row;

    logic                        i_clk     = 1'b0;
    logic                        i_rst_n   = 1'b0;
    logic                        start     = 1'b0;
    logic                        busy;
    logic [FUNC_W-1:0]           req_func  = '0;
    logic [KEY_W-1:0]            req_key   = '0;
    logic signed [VALUE_W-1:0]   req_value = '0;
    logic                        done;
    logic [STATUS_W-1:0]         rsp_status;
    logic signed [VALUE_W-1:0]   rsp_fval;
    logic [SLOT_W-1:0]           rsp_slot;

    t_mark            slot_marks  [N_SLOTS];
    logic [KEY_W-1:0] slot_keys   [N_SLOTS];
    logic [31:0]      slot_values [N_SLOTS];
    t_reply           pending_replies [$];
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    int               mismatches   = 0;
    int               stall_cycles = 0;

    t_row directed_rows [N_DIRECTED] = '{
        '{FUNC_SEARCH, 64'h41, 32'sh0, 1'b1, '{ST_NOT_FOUND, 32'sh0, 4'd0}},
        '{FUNC_DELETE, 64'h0, 32'sh0, 1'b1, '{ST_NOT_FOUND, 32'sh0, 4'd0}},
        '{FUNC_INSERT, 64'h0, 32'sh7FFF_FFFF, 1'b1, '{ST_INSERTED, 32'sh0, 4'd0}},
        '{FUNC_SEARCH, 64'h0, 32'sh0, 1'b1, '{ST_FOUND, 32'sh7FFF_FFFF, 4'd0}},
        '{FUNC_INSERT, 64'h41, 32'sh8000_0000, 1'b1, '{ST_INSERTED, 32'sh0, 4'd1}},
        '{FUNC_INSERT, 64'hFFFF_0000_0000_0041, 32'shFFFF_FFFF, 1'b1,
          '{ST_UPDATED, 32'sh0, 4'd1}},
        '{FUNC_SEARCH, 64'h41, 32'sh0, 1'b1, '{ST_FOUND, 32'shFFFF_FFFF, 4'd1}},
        '{FUNC_SEARCH, 64'h51, 32'sh0, 1'b1, '{ST_NOT_FOUND, 32'sh0, 4'd0}},
        '{FUNC_INSERT, 64'h51, 32'sh5, 1'b1, '{ST_INSERTED, 32'sh0, 4'd2}},
        '{FUNC_DELETE, 64'h41, 32'sh0, 1'b1, '{ST_FOUND, 32'sh0, 4'd1}},
        '{FUNC_SEARCH, 64'h51, 32'sh0, 1'b1, '{ST_FOUND, 32'sh5, 4'd2}},
        '{FUNC_INSERT, 64'h51, 32'sh6, 1'b1, '{ST_INSERTED, 32'sh0, 4'd1}},
        '{FUNC_SEARCH, 64'h51, 32'sh0, 1'b1, '{ST_FOUND, 32'sh6, 4'd1}},
        '{FUNC_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'sh0, 1'b1,
          '{ST_INSERTED, 32'sh0, 4'd8}},
        '{FUNC_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 32'sh0, 1'b1, '{ST_FOUND, 32'sh0, 4'd8}},
        '{FUNC_INSERT, 64'h8080_8080_8080_8080, 32'sh1234_5678, 1'b1,
          '{ST_INSERTED, 32'sh0, 4'd3}},
        '{FUNC_UNUSED, 64'h8080_8080_8080_8080, 32'sh0, 1'b1,
          '{ST_NOT_FOUND, 32'sh0, 4'd0}},
        '{FUNC_SEARCH, 64'h8080_8080_8080_8080, 32'sh0, 1'b1,
          '{ST_FOUND, 32'sh1234_5678, 4'd3}},
        '{FUNC_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 32'sh0, 1'b1, '{ST_FOUND, 32'sh0, 4'd8}},
        '{FUNC_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 32'sh0, 1'b1,
          '{ST_NOT_FOUND, 32'sh0, 4'd0}},
        '{FUNC_INSERT, 64'h6261, 32'sh55AA_55AA, 1'b0, '0},
        '{FUNC_DELETE, 64'h51, 32'sh0, 1'b0, '0}
    };

    linear_probe_hash_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_func        (req_func),
        .i_key         (req_key),
        .i_value       (req_value),
        .o_done        (done),
        .o_status      (rsp_status),
        .o_found_value (rsp_fval),
        .o_slot        (rsp_slot)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Walk the slot store the way the block does and apply the request.
    function automatic t_reply probe_slots(t_func f, logic [KEY_W-1:0] raw,
                                           logic [31:0] v);
        logic [KEY_W-1:0] k;
        int unsigned      sum;
        int unsigned      idx;
        t_reply           r;
        k   = '0;
        sum = 0;
        for (int i = 0; i < KEY_BYTES_DEF; i++) begin
            if (raw[8*i +: 8] == 8'h00) break;
            k[8*i +: 8] = raw[8*i +: 8];
            sum += raw[8*i +: 8];
        end
        idx = sum % N_SLOTS;
        r   = '{ST_NOT_FOUND, '0, '0};
        if (f == FUNC_INSERT) begin
            r.status = ST_FULL;
            for (int n = 0; n < N_SLOTS; n++) begin
                if (slot_marks[idx] != MARK_USED) begin
                    slot_marks[idx]  = MARK_USED;
                    slot_keys[idx]   = k;
                    slot_values[idx] = v;
                    r.status         = ST_INSERTED;
                    r.slot           = SLOT_W'(idx);
                    break;
                end
                if (slot_keys[idx] == k) begin
                    slot_values[idx] = v;
                    r.status         = ST_UPDATED;
                    r.slot           = SLOT_W'(idx);
                    break;
                end
                idx = (idx + 1) % N_SLOTS;
            end
        end else if (f == FUNC_SEARCH || f == FUNC_DELETE) begin
            for (int n = 0; n < N_SLOTS; n++) begin
                if (slot_marks[idx] == MARK_EMPTY) break;
                if (slot_marks[idx] == MARK_USED && slot_keys[idx] == k) begin
                    r.status = ST_FOUND;
                    r.slot   = SLOT_W'(idx);
                    if (f == FUNC_SEARCH) r.fval = slot_values[idx];
                    else slot_marks[idx] = MARK_DELETED;
                    break;
                end
                idx = (idx + 1) % N_SLOTS;
            end
        end
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] fresh_key();
        logic [KEY_W-1:0] k;
        int               len;
        bit               ascii;
        k     = '0;
        len   = $urandom_range(1, KEY_BYTES_DEF);
        ascii = $urandom_range(0, 1);
        for (int i = 0; i < len; i++) begin
            k[8*i +: 8] = ascii ? 8'($urandom_range(32, 126)) : 8'($urandom_range(1, 255));
        end
        return k;
    endfunction

    task automatic send_word(input t_func f, input logic [KEY_W-1:0] k,
                             input logic [31:0] v, input bit use_typed,
                             input t_reply typed);
        t_reply predicted;
        start     <= 1'b1;
        req_func  <= f;
        req_key   <= k;
        req_value <= v;
        do @(posedge i_clk); while (busy !== 1'b0);
        predicted = probe_slots(f, k, v);
        pending_replies.push_back(use_typed ? typed : predicted);
    endtask

    task automatic maybe_idle(input int odds);
        if (odds != 0 && $urandom_range(1, odds) == 1) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_reply want;
        if (i_rst_n && done === 1'b1) begin
            if (pending_replies.size() == 0) begin
                $error("result word with no request outstanding");
                mismatches++;
            end else begin
                want = pending_replies.pop_front();
                if (rsp_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rsp_status);
                    mismatches++;
                end
                if (rsp_fval !== want.fval) begin
                    $error("found_value: expected %0d, got %0d", want.fval, rsp_fval);
                    mismatches++;
                end
                if (rsp_slot !== want.slot) begin
                    $error("slot: expected %0d, got %0d", want.slot, rsp_slot);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || done === 1'b1) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        t_func            f;
        logic [KEY_W-1:0] k;
        int               roll;
        int               ins_pct;
        int               del_pct;
        int               gap_odds;
        int               z;
        for (int s = 0; s < N_SLOTS; s++) begin
            slot_marks[s]  = MARK_EMPTY;
            slot_keys[s]   = '0;
            slot_values[s] = '0;
        end
        for (int p = 0; p < POOL_SIZE; p++) key_pool[p] = fresh_key();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_DIRECTED; r++) begin
            send_word(directed_rows[r].func, directed_rows[r].key, directed_rows[r].value,
                      directed_rows[r].typed, directed_rows[r].reply);
            maybe_idle(3);
        end

        ins_pct  = 0;
        del_pct  = 0;
        gap_odds = 0;
        for (int w = 0; w < RANDOM_WORDS; w++) begin
            if (w % ROUND_WORDS == 0) begin
                case ((w / ROUND_WORDS) % 3)
                    0: begin
                        ins_pct = 70;
                        del_pct = 5;
                    end
                    1: begin
                        ins_pct = 35;
                        del_pct = 35;
                    end
                    default: begin
                        ins_pct = 20;
                        del_pct = 20;
                    end
                endcase
                case ($urandom_range(0, 2))
                    0: gap_odds = 0;
                    1: gap_odds = 4;
                    default: gap_odds = 2;
                endcase
                repeat (4) key_pool[$urandom_range(0, POOL_SIZE - 1)] = fresh_key();
            end
            if (w >= RANDOM_WORDS - CALM_WORDS) gap_odds = 0;

            roll = $urandom_range(0, 99);
            if (roll < ins_pct) f = FUNC_INSERT;
            else if (roll < ins_pct + del_pct) f = FUNC_DELETE;
            else if (roll < 98) f = FUNC_SEARCH;
            else f = FUNC_UNUSED;

            roll = $urandom_range(0, 19);
            if (roll == 0) begin
                k = {$urandom, $urandom};
            end else if (roll == 1) begin
                k = '0;
            end else begin
                k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                // fill the bytes past the terminating zero with junk
                if ($urandom_range(0, 3) == 0) begin
                    z = KEY_BYTES_DEF;
                    for (int i = 0; i < KEY_BYTES_DEF; i++) begin
                        if (k[8*i +: 8] == 8'h00 && z == KEY_BYTES_DEF) z = i;
                    end
                    for (int i = z + 1; i < KEY_BYTES_DEF; i++) begin
                        k[8*i +: 8] = 8'($urandom_range(0, 255));
                    end
                end
            end
            send_word(f, k, $urandom, 1'b0, '0);
            maybe_idle(gap_odds);
        end
        start <= 1'b0;

        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
